>>> rtl/sphere_quad_vertex_generator_assert.svh
// Assertion macros for the sphere quad vertex generator
`ifndef SPHERE_QUAD_VERTEX_GENERATOR_ASSERT_SVH
`define SPHERE_QUAD_VERTEX_GENERATOR_ASSERT_SVH

// Implication checked on every clock, muted during reset
`define SQV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, muted during reset
`define SQV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sqv_pkg.sv
// ---------------------------------------------------------------------------
// sqv_pkg
// Shared types and constants of the sphere quad vertex generator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package sqv_pkg;

   localparam int CfgIdxBits = 3;
   localparam int CfgDataBits = 32;

   typedef enum logic [CfgIdxBits-1:0] {
      REG_CENTER_X = 3'd0,
      REG_CENTER_Y = 3'd1,
      REG_CENTER_Z = 3'd2,
      REG_RADIUS   = 3'd3,
      REG_STEP     = 3'd4
   } reg_index_type;

   localparam logic signed [31:0] GainQ30 = 32'sd652032874;
   localparam logic signed [31:0] OneQ30 = 32'sd1073741824;
   localparam int AtanLen = 24;

   typedef struct packed {
      logic [7:0] ring_index;
      logic [7:0] column_index;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic               last_vertex;
   } rsp_type;

   function automatic logic signed [31:0] atan_turn(input int i);
      logic signed [31:0] r;
      begin
         case (i)
            0: r = 32'sd536870912;   1: r = 32'sd316933406;
            2: r = 32'sd167458907;   3: r = 32'sd85004756;
            4: r = 32'sd42667331;    5: r = 32'sd21354465;
            6: r = 32'sd10679838;    7: r = 32'sd5340245;
            8: r = 32'sd2670163;     9: r = 32'sd1335087;
            10: r = 32'sd667544;     11: r = 32'sd333772;
            12: r = 32'sd166886;     13: r = 32'sd83443;
            14: r = 32'sd41722;      15: r = 32'sd20861;
            16: r = 32'sd10430;      17: r = 32'sd5215;
            18: r = 32'sd2608;       19: r = 32'sd1304;
            20: r = 32'sd652;        21: r = 32'sd326;
            22: r = 32'sd163;        23: r = 32'sd81;
            default: r = 32'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

>>> rtl/sphere_quad_vertex_generator.sv
// One vertex a cycle leaves while the front has a quad and the queue is not full.
// A new quad is taken as the last of the six vertex slots of the front is pushed.
// The back pipeline never stalls: rsp_valid strobes for one cycle per vertex.
// Reset (synchronous): empties queue and pipeline, center 0, radius 1.0, step 1024.
// ---------------------------------------------------------------------------
// sphere_quad_vertex_generator
// UV sphere quad tessellator: six vertices (position, normal) per quad.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sphere_quad_vertex_generator_assert.svh"
module sphere_quad_vertex_generator #(
   parameter int ANGLE_BITS = 16,
   parameter int INDEX_BITS = 8,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  sqv_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   output sqv_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [sqv_pkg::CfgIdxBits-1:0]     csr_index,
   input  logic [sqv_pkg::CfgDataBits-1:0]    csr_wdata
);
   import sqv_pkg::*;

   localparam int QW = 2*ANGLE_BITS + 1;

   logic signed [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0]        rad_ff;
   logic [15:0]        step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0; cy_ff <= '0; cz_ff <= '0;
         rad_ff <= 31'd65536; step_ff <= 16'd1024;
      end else if (csr_we) begin
         case (csr_index)
            REG_CENTER_X: cx_ff <= csr_wdata;
            REG_CENTER_Y: cy_ff <= csr_wdata;
            REG_CENTER_Z: cz_ff <= csr_wdata;
            REG_RADIUS:   rad_ff <= csr_wdata[30:0];
            REG_STEP:     step_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic [ANGLE_BITS-1:0] step;
   assign step = ANGLE_BITS'(step_ff);

   logic          q_full, q_push, q_ne;
   logic [QW-1:0] q_wd, q_rd;

   sqv_front #(.ANGLE_BITS(ANGLE_BITS), .INDEX_BITS(INDEX_BITS)) u_front (
      .clock, .reset, .start, .busy, .req_data, .step,
      .q_full, .q_push, .q_data(q_wd)
   );

   sqv_fifo #(.WIDTH(QW)) u_fifo (
      .clock, .reset, .push(q_push), .push_data(q_wd), .full(q_full),
      .pop(q_ne), .not_empty(q_ne), .pop_data(q_rd)
   );

   sqv_back #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_back (
      .clock, .reset, .in_valid(q_ne), .in_data(q_rd),
      .center_x(cx_ff), .center_y(cy_ff), .center_z(cz_ff), .radius(rad_ff),
      .out_valid(rsp_valid), .out_data(rsp_data)
   );

   `SQV_ASSERT_IMP(a_no_push_full, clock, reset, q_full, !q_push, "push into full queue")
   `SQV_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy, "idle after start")
   `SQV_ASSERT_IMP(a_norm_range, clock, reset, rsp_valid, rsp_data.norm_z != 16'sh8000, "bad norm")
endmodule

>>> rtl/sqv_front.sv
// ---------------------------------------------------------------------------
// sqv_front
// Accepts quad requests, computes the angle pairs of the six vertices and
// pushes them one per cycle, while the queue is not full, into a small queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sqv_front #(
   parameter int ANGLE_BITS = 16,
   parameter int INDEX_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sqv_pkg::req_type       req_data,
   input  logic [ANGLE_BITS-1:0]  step,
   input  logic                   q_full,
   output logic                   q_push,
   output logic [2*ANGLE_BITS:0]  q_data
);
   import sqv_pkg::*;

   localparam int AB = ANGLE_BITS;

   logic [AB-1:0] phi_ff, phi_in, phi2_ff, phi2_in;
   logic [AB-1:0] t1_ff, t1_in, t2_ff, t2_in, t1s_ff, t1s_in, t2s_ff, t2s_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic          act_ff, act_in;
   logic [INDEX_BITS-1:0] ring, col;
   logic [AB-1:0] base, half, ph, th;
   logic [AB+INDEX_BITS-1:0] pr, pc;
   logic          take, adv;

   assign ring = INDEX_BITS'(req_data.ring_index);
   assign col  = INDEX_BITS'(req_data.column_index);
   assign pr   = ring * step;
   assign pc   = col * step;
   assign base = pc[AB-1:0];
   assign half = step >> 1;

   // a new quad may enter as the last vertex of the current one is pushed
   assign adv  = act_ff && !q_full;
   assign busy = act_ff && !(adv && cnt_ff == 3'd5);
   assign take = start && !busy;

   always_comb begin
      case (cnt_ff)
         3'd0: begin ph = phi_ff;  th = t1_ff;  end
         3'd1: begin ph = phi2_ff; th = t2_ff;  end
         3'd2: begin ph = phi_ff;  th = t1s_ff; end
         3'd3: begin ph = phi_ff;  th = t1s_ff; end
         3'd4: begin ph = phi2_ff; th = t2_ff;  end
         3'd5: begin ph = phi2_ff; th = t2s_ff; end
         default: begin ph = phi_ff; th = t1_ff; end
      endcase
   end

   assign q_push = adv;
   assign q_data = {ph, th, cnt_ff == 3'd5};

   always_comb begin
      phi_in = phi_ff; phi2_in = phi2_ff; t1_in = t1_ff; t2_in = t2_ff;
      t1s_in = t1s_ff; t2s_in = t2s_ff;
      cnt_in = cnt_ff; act_in = act_ff;
      if (adv) begin
         cnt_in = (cnt_ff == 3'd5) ? 3'd0 : cnt_ff + 3'd1;
         if (cnt_ff == 3'd5) act_in = 1'b0;
      end
      if (take) begin
         phi_in  = pr[AB-1:0];
         phi2_in = pr[AB-1:0] + step;
         t1_in   = ring[0] ? base + half : base;
         t2_in   = ring[0] ? base : base + half;
         t1s_in  = (ring[0] ? base + half : base) + step;
         t2s_in  = (ring[0] ? base : base + half) + step;
         cnt_in  = 3'd0;
         act_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         cnt_ff <= 3'd0;
      end else begin
         act_ff <= act_in;
         cnt_ff <= cnt_in;
      end
      phi_ff <= phi_in; phi2_ff <= phi2_in; t1_ff <= t1_in; t2_ff <= t2_in;
      t1s_ff <= t1s_in; t2s_ff <= t2s_in;
   end
endmodule

>>> rtl/sqv_fifo.sv
// ---------------------------------------------------------------------------
// sqv_fifo
// Short queue of vertex angle pairs between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sqv_fifo #(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   import sqv_pkg::*;

   logic [WIDTH-1:0] mem_ff [4];
   logic [1:0]       wp_ff, rp_ff;
   logic [2:0]       cnt_ff;

   assign full      = cnt_ff == 3'd4;
   assign not_empty = cnt_ff != 3'd0;
   assign pop_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, push} - {2'd0, pop};
      end
      if (push) mem_ff[wp_ff] <= push_data;
   end
endmodule

>>> rtl/sqv_back.sv
// ---------------------------------------------------------------------------
// sqv_back
// Pipelined vertex unit: two CORDIC rotators, direction products and the
// position/normal output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sqv_back #(
   parameter int ANGLE_BITS = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [2*ANGLE_BITS:0]   in_data,
   input  logic signed [31:0]      center_x,
   input  logic signed [31:0]      center_y,
   input  logic signed [31:0]      center_z,
   input  logic [30:0]             radius,
   output logic                    out_valid,
   output sqv_pkg::rsp_type        out_data
);
   import sqv_pkg::*;

   localparam int AB = ANGLE_BITS;
   localparam int NS = CORDIC_STAGES;
   localparam int CW = 34;

   // stage 0: fold angles
   logic signed [CW-1:0] px_ff [NS+1], py_ff [NS+1], tx_ff [NS+1], ty_ff [NS+1];
   logic signed [32:0]   pz_ff [NS+1], tz_ff [NS+1];
   logic                 pf_ff [NS+1], tf_ff [NS+1], lst_ff [NS+1], v_ff [NS+1];

   function automatic logic [32:0] fold(input logic [AB-1:0] ang);
      logic [31:0] a;
      begin
         a = {ang, {(32-AB){1'b0}}};
         if (a[31] != a[30]) return {1'b1, a - 32'h8000_0000};
         return {1'b0, a};
      end
   endfunction

   logic [32:0] fp, ft;
   assign fp = fold(in_data[2*AB:AB+1]);
   assign ft = fold(in_data[AB:1]);

   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else v_ff[0] <= in_valid;
      px_ff[0] <= CW'(GainQ30); py_ff[0] <= '0;
      tx_ff[0] <= CW'(GainQ30); ty_ff[0] <= '0;
      pz_ff[0] <= 33'(signed'(fp[31:0])); tz_ff[0] <= 33'(signed'(ft[31:0]));
      pf_ff[0] <= fp[32]; tf_ff[0] <= ft[32]; lst_ff[0] <= in_data[0];
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < NS; i++) begin : g_rot
      localparam int SH = i;
      logic signed [32:0] at;
      assign at = (i < AtanLen) ? 33'(atan_turn(i)) : 33'sd0;
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else v_ff[i+1] <= v_ff[i];
         if (!pz_ff[i][32]) begin
            px_ff[i+1] <= px_ff[i] - (py_ff[i] >>> SH);
            py_ff[i+1] <= py_ff[i] + (px_ff[i] >>> SH);
            pz_ff[i+1] <= pz_ff[i] - at;
         end else begin
            px_ff[i+1] <= px_ff[i] + (py_ff[i] >>> SH);
            py_ff[i+1] <= py_ff[i] - (px_ff[i] >>> SH);
            pz_ff[i+1] <= pz_ff[i] + at;
         end
         if (!tz_ff[i][32]) begin
            tx_ff[i+1] <= tx_ff[i] - (ty_ff[i] >>> SH);
            ty_ff[i+1] <= ty_ff[i] + (tx_ff[i] >>> SH);
            tz_ff[i+1] <= tz_ff[i] - at;
         end else begin
            tx_ff[i+1] <= tx_ff[i] + (ty_ff[i] >>> SH);
            ty_ff[i+1] <= ty_ff[i] - (tx_ff[i] >>> SH);
            tz_ff[i+1] <= tz_ff[i] + at;
         end
         pf_ff[i+1] <= pf_ff[i]; tf_ff[i+1] <= tf_ff[i]; lst_ff[i+1] <= lst_ff[i];
      end
   end

   function automatic logic signed [31:0] fin(input logic signed [CW-1:0] v,
                                              input logic f);
      logic signed [CW-1:0] n;
      begin
         n = f ? -v : v;
         if (n > CW'(OneQ30)) return OneQ30;
         if (n < -CW'(OneQ30)) return -OneQ30;
         return n[31:0];
      end
   endfunction

   // stage A: clamp sin/cos
   logic signed [31:0] sp_ff, cp_ff, st_ff, ct_ff;
   logic               va_ff, la_ff;
   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else va_ff <= v_ff[NS];
      cp_ff <= fin(px_ff[NS], pf_ff[NS]); sp_ff <= fin(py_ff[NS], pf_ff[NS]);
      ct_ff <= fin(tx_ff[NS], tf_ff[NS]); st_ff <= fin(ty_ff[NS], tf_ff[NS]);
      la_ff <= lst_ff[NS];
   end

   // stage B: direction products, rounded to Q1.30
   logic signed [63:0] mx, my;
   logic signed [31:0] dx_ff, dy_ff, dz_ff;
   logic               vb_ff, lb_ff;
   assign mx = sp_ff * ct_ff + 64'sd536870912;
   assign my = sp_ff * st_ff + 64'sd536870912;
   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else vb_ff <= va_ff;
      dx_ff <= 32'(mx >>> 30); dy_ff <= 32'(my >>> 30); dz_ff <= cp_ff;
      lb_ff <= la_ff;
   end

   // stage C: radius products
   logic signed [63:0] rx_ff, ry_ff, rz_ff;
   logic signed [31:0] dx2_ff, dy2_ff, dz2_ff;
   logic               vc_ff, lc_ff;
   logic signed [31:0] rs;
   assign rs = {1'b0, radius};
   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else vc_ff <= vb_ff;
      rx_ff <= rs * dx_ff + 64'sd536870912;
      ry_ff <= rs * dy_ff + 64'sd536870912;
      rz_ff <= rs * dz_ff + 64'sd536870912;
      dx2_ff <= dx_ff; dy2_ff <= dy_ff; dz2_ff <= dz_ff; lc_ff <= lb_ff;
   end

   function automatic logic signed [31:0] sat(input logic signed [31:0] c,
                                              input logic signed [63:0] p);
      logic signed [34:0] s;
      begin
         s = 35'(c) + 35'(p >>> 30);
         if (s > 35'sd2147483647) return 32'h7fff_ffff;
         if (s < -35'sd2147483648) return 32'h8000_0000;
         return s[31:0];
      end
   endfunction

   function automatic logic signed [15:0] nrm(input logic signed [31:0] d);
      logic signed [32:0] n;
      begin
         n = (33'(d) + 33'sd16384) >>> 15;
         if (n > 33'sd32767) return 16'sd32767;
         if (n < -33'sd32767) return -16'sd32767;
         return n[15:0];
      end
   endfunction

   // stage D: output register
   rsp_type o_ff;
   logic    vo_ff;
   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else vo_ff <= vc_ff;
      o_ff.pos_x <= sat(center_x, rx_ff);
      o_ff.pos_y <= sat(center_y, ry_ff);
      o_ff.pos_z <= sat(center_z, rz_ff);
      o_ff.norm_x <= nrm(dx2_ff);
      o_ff.norm_y <= nrm(dy2_ff);
      o_ff.norm_z <= nrm(dz2_ff);
      o_ff.last_vertex <= lc_ff;
   end

   assign out_valid = vo_ff;
   assign out_data  = o_ff;
endmodule

>>> dv/sphere_quad_vertex_generator_tb.sv
// ---------------------------------------------------------------------------
// sphere_quad_vertex_generator_tb
// Drives quad requests and register settings into the vertex generator and
// checks each vertex beat against a bit-exact CORDIC predictor in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module sphere_quad_vertex_generator_tb;
   import sqv_pkg::*;

   localparam logic [CfgIdxBits-1:0] REG_UNUSED = 3'd7;
   localparam int DrainCycles = 40;
   localparam int IdleLimit = 5000;
   localparam int PhaseItems = 39;

   class vertex_scoreboard;
      rsp_type expected_vertices[$];
      int errors;
      logic signed [31:0] cx, cy, cz;
      logic [30:0] radius;
      logic [15:0] step;

      function new();
         cx = 0; cy = 0; cz = 0; radius = 31'd65536; step = 16'd1024; errors = 0;
      endfunction

      function void set_reg(logic [CfgIdxBits-1:0] idx, logic [31:0] val);
         case (idx)
            REG_CENTER_X: cx = val;
            REG_CENTER_Y: cy = val;
            REG_CENTER_Z: cz = val;
            REG_RADIUS:   radius = val[30:0];
            REG_STEP:     step = val[15:0];
            default: ;
         endcase
      endfunction

      function void sin_cos(logic [15:0] ang, output longint s, output longint c);
         logic [31:0] a;
         logic flip;
         longint x, y, z, dx, dy;
         a = {ang, 16'h0};
         flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
         if (flip) a = a - 32'h8000_0000;
         x = GainQ30;
         y = 0;
         z = longint'(signed'(a));
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(atan_turn(i));
            end else begin
               x += dx; y -= dy; z += longint'(atan_turn(i));
            end
         end
         if (flip) begin
            x = -x; y = -y;
         end
         c = (x > OneQ30) ? longint'(OneQ30) : (x < -OneQ30) ? -longint'(OneQ30) : x;
         s = (y > OneQ30) ? longint'(OneQ30) : (y < -OneQ30) ? -longint'(OneQ30) : y;
      endfunction

      function longint mul_q30(longint a, longint b);
         return (a * b + (64'sd1 <<< 29)) >>> 30;
      endfunction

      function logic signed [31:0] place(logic signed [31:0] ctr, longint dir);
         longint p;
         p = longint'(ctr) + mul_q30(longint'(radius), dir);
         if (p > 64'sd2147483647) p = 64'sd2147483647;
         if (p < -64'sd2147483648) p = -64'sd2147483648;
         return p[31:0];
      endfunction

      function logic signed [15:0] unit(longint dir);
         longint n;
         n = (dir + (64'sd1 <<< 14)) >>> 15;
         if (n > 32767) n = 32767;
         if (n < -32767) n = -32767;
         return n[15:0];
      endfunction

      function rsp_type vertex(logic [15:0] phi, logic [15:0] theta, logic last);
         rsp_type v;
         longint sp, cp, st, ct, dx, dy;
         sin_cos(phi, sp, cp);
         sin_cos(theta, st, ct);
         dx = mul_q30(sp, ct);
         dy = mul_q30(sp, st);
         v.pos_x = place(cx, dx);
         v.pos_y = place(cy, dy);
         v.pos_z = place(cz, cp);
         v.norm_x = unit(dx);
         v.norm_y = unit(dy);
         v.norm_z = unit(cp);
         v.last_vertex = last;
         return v;
      endfunction

      function void add_expected(rsp_type v);
         expected_vertices = {expected_vertices, v};
      endfunction

      function void note_quad(req_type q);
         logic [15:0] phi, phi2, base, t1, t2, half;
         half = step >> 1;
         phi = q.ring_index * step;
         phi2 = phi + step;
         base = q.column_index * step;
         t1 = q.ring_index[0] ? base + half : base;
         t2 = q.ring_index[0] ? base : base + half;
         add_expected(vertex(phi, t1, 1'b0));
         add_expected(vertex(phi2, t2, 1'b0));
         add_expected(vertex(phi, t1 + step, 1'b0));
         add_expected(vertex(phi, t1 + step, 1'b0));
         add_expected(vertex(phi2, t2, 1'b0));
         add_expected(vertex(phi2, t2 + step, 1'b1));
      endfunction

      function void check_vertex(rsp_type got);
         rsp_type want;
         if (expected_vertices.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected vertex %h", got);
            return;
         end
         want = expected_vertices.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display({"vertex mismatch: exp pos %h %h %h nrm %h %h %h last %b,",
                         " got pos %h %h %h nrm %h %h %h last %b"},
                        want.pos_x, want.pos_y, want.pos_z, want.norm_x, want.norm_y,
                        want.norm_z, want.last_vertex, got.pos_x, got.pos_y, got.pos_z,
                        got.norm_x, got.norm_y, got.norm_z, got.last_vertex);
         end
      endfunction
   endclass

   logic clock, reset, start, busy, rsp_valid, csr_we;
   req_type req_data;
   rsp_type rsp_data;
   logic [CfgIdxBits-1:0] csr_index;
   logic [CfgDataBits-1:0] csr_wdata;
   vertex_scoreboard sb;
   int idle_cycles;
   int burst_left;

   sphere_quad_vertex_generator dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_vertex(rsp_data);
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("sphere_quad_vertex_generator regression: fail");
         $finish;
      end
   end

   task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.set_reg(idx, val);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold start across a burst; drop it only when a gap follows.
   task automatic send_quad(logic [7:0] ring, logic [7:0] col);
      @(posedge clock);
      req_data <= {ring, col};
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_quad({ring, col});
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 7);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(0, 12)) @(posedge clock);
         end
      end
   endtask

   task automatic settle();
      @(posedge clock);
      start <= 1'b0;
      while (sb.expected_vertices.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_phase(int p);
      case (p)
         0: begin
            write_reg(REG_STEP, {16'($urandom_range(0, 65535)), 16'd0});
            write_reg(REG_RADIUS, 32'h8000_0000 | 32'd65536);
         end
         1: write_reg(REG_STEP, 32'd0);
         2: write_reg(REG_STEP, 32'hFFFF);
         3: begin
            write_reg(REG_STEP, 32'd1);
            write_reg(REG_RADIUS, 32'd0);
            write_reg(REG_CENTER_X, $urandom);
         end
         4: begin
            write_reg(REG_STEP, $urandom_range(1, 65535));
            write_reg(REG_RADIUS, 32'h7FFF_FFFF);
            write_reg(REG_CENTER_X, 32'h7FFF_FFFF);
            write_reg(REG_CENTER_Y, 32'h8000_0000);
            write_reg(REG_CENTER_Z, 32'h7FFF_0000);
         end
         5: begin
            write_reg(REG_CENTER_X, 32'h8000_0000);
            write_reg(REG_CENTER_Y, 32'h7FFF_FFFF);
            write_reg(REG_CENTER_Z, 32'h8000_0000);
            write_reg(REG_UNUSED, $urandom);
         end
         default: begin
            write_reg(REG_CENTER_X, $urandom);
            write_reg(REG_CENTER_Y, $urandom);
            write_reg(REG_CENTER_Z, $urandom);
            write_reg(REG_RADIUS, $urandom);
            write_reg(REG_STEP, $urandom);
         end
      endcase
   endtask

   initial begin
      sb = new();
      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_index <= REG_CENTER_X;
      csr_wdata <= '0;
      idle_cycles = 0;
      burst_left = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed corners at reset settings: index extremes and both parities.
      send_quad(8'd0, 8'd0);
      send_quad(8'd1, 8'd0);
      send_quad(8'd255, 8'd255);
      send_quad(8'd254, 8'd1);
      send_quad(8'd128, 8'd127);
      send_quad(8'd63, 8'd192);
      settle();
      write_reg(REG_STEP, 32'd0);
      send_quad(8'd7, 8'd200);
      send_quad(8'd8, 8'd3);
      settle();
      write_reg(REG_RADIUS, 32'd0);
      write_reg(REG_STEP, 32'hFFFF);
      send_quad(8'd255, 8'd0);
      send_quad(8'd2, 8'd255);
      settle();

      for (int p = 0; p < 9; p++) begin
         set_phase(p);
         for (int i = 0; i < PhaseItems; i++)
            send_quad($urandom_range(0, 255), $urandom_range(0, 255));
         settle();
      end

      if (sb.errors == 0 && sb.expected_vertices.size() == 0)
         $display("sphere_quad_vertex_generator regression: pass");
      else
         $display("sphere_quad_vertex_generator regression: fail");
      $finish;
   end
endmodule
